### sv/isort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_pkg
// Shared data width, default depth and cell control type for the insertion sorter.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W     = 32;
    localparam int SORT_DEPTH = 16;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the broadcast value, shifting larger ones up
        logic shift;    // move every entry one place towards cell 0
    } cell_ctl_t;

endpackage : isort_pkg
`default_nettype wire

### sv/isort_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorting chain: compares against the broadcast value and
// takes either the new value, its lower neighbour's entry or its upper one.
// ----------------------------------------------------------------------------
module isort_cell
    import isort_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctl_t                ctl,
    input  wire logic signed [DATA_W-1:0] ins_val,
    input  wire logic signed [DATA_W-1:0] lo_val,
    input  wire logic                     lo_vld,
    input  wire logic                     lo_gt,
    input  wire logic signed [DATA_W-1:0] hi_val,
    input  wire logic                     hi_vld,
    output logic signed [DATA_W-1:0]      val,
    output logic                          vld,
    output logic                          gt
);

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     vld_reg;
    logic                     vld_next;

    // an empty slot behaves as +infinity, so the free end fills naturally
    assign gt = !vld_reg || (val_reg > ins_val);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctl.insert && gt)
        begin
            if (lo_gt)
            begin
                val_next = lo_val;
                vld_next = lo_vld;
            end
            else
            begin
                val_next = ins_val;
                vld_next = 1'b1;
            end
        end
        else if (ctl.shift)
        begin
            val_next = hi_val;
            vld_next = hi_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule : isort_cell
`default_nettype wire

### sv/insertion_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sorter
// Sorts a run of signed values ascending in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one element_value per request, is_final
// on the last of a run. Each accepted element is placed into the chain in the
// same cycle, so elements are taken one per cycle while a run is being loaded.
// Once is_final is accepted the block drains: in_stall is held high and the run
// leaves from cell 0 on the output channel (out_valid / out_stall), one request
// per cycle unless stalled, ascending, equal values in arrival order, run_last
// on the final one and overflowed on all of them if elements past DEPTH were
// dropped. The first result is presented in the cycle after the final request;
// a run of n held elements leaves through the single output port at cell 0.
// While out_stall is high the chain holds and the result stays unchanged.
// Reset empties the chain and clears the count and the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int DEPTH = SORT_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] element_value,
    input  wire logic                     is_final,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      sorted_value,
    output logic                          run_last,
    output logic                          overflowed
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             draining_reg;
    logic             draining_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic      in_acc;
    logic      out_acc;
    logic      full;
    cell_ctl_t ctl;

    logic signed [DATA_W-1:0] cell_val [DEPTH];
    logic                     cell_vld [DEPTH];
    logic                     cell_gt  [DEPTH];
    logic signed [DATA_W-1:0] lo_val   [DEPTH];
    logic                     lo_vld   [DEPTH];
    logic                     lo_gt    [DEPTH];
    logic signed [DATA_W-1:0] hi_val   [DEPTH];
    logic                     hi_vld   [DEPTH];

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign in_acc     = in_valid && !draining_reg;
    assign out_acc    = draining_reg && !out_stall;
    assign ctl.insert = in_acc && !full;
    assign ctl.shift  = out_acc;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign lo_val[i] = '0;
                assign lo_vld[i] = 1'b0;
                assign lo_gt[i]  = 1'b0;
            end
            else
            begin : g_mid_lo
                assign lo_val[i] = cell_val[i-1];
                assign lo_vld[i] = cell_vld[i-1];
                assign lo_gt[i]  = cell_gt[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign hi_val[i] = '0;
                assign hi_vld[i] = 1'b0;
            end
            else
            begin : g_mid_hi
                assign hi_val[i] = cell_val[i+1];
                assign hi_vld[i] = cell_vld[i+1];
            end

            isort_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .ins_val (element_value),
                .lo_val  (lo_val[i]),
                .lo_vld  (lo_vld[i]),
                .lo_gt   (lo_gt[i]),
                .hi_val  (hi_val[i]),
                .hi_vld  (hi_vld[i]),
                .val     (cell_val[i]),
                .vld     (cell_vld[i]),
                .gt      (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next = draining_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        if (in_acc)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (is_final)
            begin
                draining_next = 1'b1;
            end
        end
        else if (out_acc)
        begin
            count_next = count_reg - CNT_W'(1);
            if (run_last)
            begin
                draining_next = 1'b0;
                ovf_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    assign in_stall     = draining_reg;
    assign out_valid    = draining_reg;
    assign sorted_value = cell_val[0];
    assign run_last     = (count_reg == CNT_W'(1));
    assign overflowed   = ovf_reg;

endmodule : insertion_sorter
`default_nettype wire

### sv/isort_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks on the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isort_checker
    import isort_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_stall,
    input wire logic                     is_final,
    input wire logic                     out_valid,
    input wire logic                     out_stall,
    input wire logic signed [DATA_W-1:0] sorted_value,
    input wire logic                     run_last,
    input wire logic                     overflowed
);

    logic out_acc;
    assign out_acc = out_valid && !out_stall;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value)
            && $stable(run_last) && $stable(overflowed))
        else $error("result changed while stalled");

    // no new requests taken while a run drains
    a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during drain");

    // results ascend and keep the overflow mark within a run
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !run_last |=> out_valid
            && (sorted_value >= $past(sorted_value))
            && (overflowed == $past(overflowed)))
        else $error("run out of order or broken");

    // drain ends with the last result
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && run_last |=> !out_valid)
        else $error("results after run end");

    // a final request starts the drain
    a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_final |=> out_valid)
        else $error("final request did not start output");

endmodule : isort_checker

bind insertion_sorter isort_checker u_isort_checker (.*);
`default_nettype wire
